// File: hdl/rpq_pkg.sv
// shared types and constants of the ready priority queue
package rpq_pkg;

	localparam int DEPTH_DEF = 128;

	localparam int TASK_W = 7;
	localparam int PRIO_W = 8;
	localparam int OPC_W  = 2;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 8;

	typedef enum logic [OPC_W-1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_REM = 2'd2
	} opcode_t;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_REMOVE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ROTATE,
		CELL_WRITE,
		CELL_CLOSE
	} cell_op_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   data;
	} cell_cmd_t;

endpackage

// File: hdl/rpq_if.sv
// request and response channel interfaces of the ready priority queue
interface rpq_req_if
	import rpq_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [TASK_W-1:0] task_id;
	logic [PRIO_W-1:0] prio;

	modport source (output valid, output opcode, output task_id, output prio, input ready);
	modport sink   (input valid, input opcode, input task_id, input prio, output ready);
endinterface

interface rpq_rsp_if
	import rpq_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [TASK_W-1:0] out_task_id;
	logic [STAT_W-1:0] status;
	logic [OCC_W-1:0]  occupancy;

	modport source (output valid, output out_task_id, output status, output occupancy,
		input ready);
	modport sink   (input valid, input out_task_id, input status, input occupancy,
		output ready);
endinterface

// File: hdl/rpq_cell.sv
// one queue slot: holds an entry and takes its neighbour's on shift
module rpq_cell
	import rpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                         clk,
	input  cell_cmd_t                    cmd,
	input  logic [$clog2(DEPTH+1)-1:0]   count,
	input  logic [$clog2(DEPTH)-1:0]     pos,
	input  entry_t                       next_entry,
	input  entry_t                       head_entry,
	output entry_t                       entry
);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	entry_t entry_q;
	logic   is_last;

	assign is_last = (MY_CNT == count - CNT_W'(1));
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_WRITE: begin
				if (MY_CNT == count) entry_q <= cmd.data;
			end
			CELL_ROTATE: begin
				// the tail wraps round to take the head
				if (is_last) entry_q <= head_entry;
				else if (MY_CNT < count) entry_q <= next_entry;
			end
			CELL_CLOSE: begin
				if (MY_IDX >= pos && MY_CNT < count - CNT_W'(1)) entry_q <= next_entry;
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/rpq_ctrl.sv
// sequencer: scans the head cell while the chain rotates, then closes the gap
module rpq_ctrl
	import rpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rpq_req_if.sink                      req,
	rpq_rsp_if.source                    rsp,
	input  entry_t                       head_entry,
	output cell_cmd_t                    cmd,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic [$clog2(DEPTH)-1:0]     pos
);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int IDX_W = $clog2(DEPTH);

	state_t            state_q, state_d;
	logic [OPC_W-1:0]  op_q;
	logic [TASK_W-1:0] tid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  k_q;
	logic [IDX_W-1:0]  pos_q;
	logic [PRIO_W-1:0] best_q;
	logic [TASK_W-1:0] id_q;
	logic              found_q;
	logic [TASK_W-1:0] res_id_q;
	logic [STAT_W-1:0] res_stat_q;
	logic              out_valid_q;
	logic [TASK_W-1:0] out_id_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [OCC_W-1:0]  out_occ_q;

	logic full, empty, scan_last, out_free;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign scan_last = (CNT_W'(k_q) == count_q - CNT_W'(1));
	assign out_free  = !out_valid_q || rsp.ready;

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.out_task_id = out_id_q;
	assign rsp.status      = out_stat_q;
	assign rsp.occupancy   = out_occ_q;
	assign count           = count_q;
	assign pos             = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.op        = CELL_HOLD;
		cmd.data      = '{task_id: tid_q, prio: prio_q};
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				if (op_q == OP_ENQ) begin
					if (!full) cmd.op = CELL_WRITE;
				end else if ((op_q == OP_DEQ || op_q == OP_REM) && !empty) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.op = CELL_ROTATE;
				if (scan_last) state_d = ST_REMOVE;
			end
			ST_REMOVE: begin
				if (found_q) cmd.op = CELL_CLOSE;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EXEC && op_q == OP_ENQ && !full)
				count_q <= count_q + CNT_W'(1);
			else if (state_q == ST_REMOVE && found_q)
				count_q <= count_q - CNT_W'(1);

			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_q   <= req.opcode;
					tid_q  <= req.task_id;
					prio_q <= req.prio;
				end
			end
			ST_EXEC: begin
				k_q        <= '0;
				found_q    <= 1'b0;
				res_id_q   <= '0;
				res_stat_q <= STAT_NONE;
				if (op_q == OP_ENQ) begin
					if (full) begin
						res_stat_q <= STAT_FULL;
					end else begin
						res_id_q   <= tid_q;
						res_stat_q <= STAT_OK;
					end
				end
			end
			ST_SCAN: begin
				k_q <= k_q + IDX_W'(1);
				if (op_q == OP_DEQ) begin
					// strict compare keeps the first of equal priorities
					if (!found_q || head_entry.prio > best_q) begin
						found_q <= 1'b1;
						best_q  <= head_entry.prio;
						pos_q   <= k_q;
						id_q    <= head_entry.task_id;
					end
				end else if (head_entry.task_id == tid_q) begin
					// later match overrides, so the last one wins
					found_q <= 1'b1;
					pos_q   <= k_q;
					id_q    <= tid_q;
				end
			end
			ST_REMOVE: begin
				if (found_q) begin
					res_id_q   <= id_q;
					res_stat_q <= STAT_OK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_id_q   <= res_id_q;
					out_stat_q <= res_stat_q;
					out_occ_q  <= OCC_W'(count_q);
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/ready_priority_queue_top.sv
// ready priority queue: a chain of entry cells under one sequencer
// enqueue and empty/unknown opcodes pass through the exec and done states to a registered
// response word; dequeue and remove scan each entry in turn, then pass the remove state
// throughput: one request word at a time; the next is taken once the response is registered
// the full rotation of the occupied cells sets the time taken by dequeue and remove
// reset clears the state machine, occupancy and response valid; cell contents need no reset
module ready_priority_queue_top
	import rpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rpq_req_if.sink    req,
	rpq_rsp_if.source  rsp
);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int IDX_W = $clog2(DEPTH);

	// command broadcast to every cell, plus the shared occupancy and gap position
	cell_cmd_t        cmd;
	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] pos;

	// contents of each cell; cell 0 is the head of the queue
	entry_t entries [DEPTH];

	rpq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.head_entry (entries[0]),
		.cmd        (cmd),
		.count      (count),
		.pos        (pos)
	);

	// each cell takes entries only from its right-hand neighbour, the head and the write
	// command, so a rotation walks every entry past the sequencer one per cycle
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t nxt;
		if (i == DEPTH - 1) begin : g_end
			// last cell never shifts from the right; feed back its own word
			assign nxt = entries[i];
		end else begin : g_mid
			assign nxt = entries[i+1];
		end

		rpq_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count),
			.pos        (pos),
			.next_entry (nxt),
			.head_entry (entries[0]),
			.entry      (entries[i])
		);
	end

endmodule
